[design/antialiased_line_rasterizer_macros.svh]
// Assertion macros for the antialiased line rasterizer.
// Each macro checks an implication under the block clock and async reset.
`ifndef ANTIALIASED_LINE_RASTERIZER_MACROS_SVH
`define ANTIALIASED_LINE_RASTERIZER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ALR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alr assertion failed");

// Next-cycle implication.
`define ALR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alr assertion failed");

`else

`define ALR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ALR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/alr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alr_pkg
// Shared constants for the antialiased line rasterizer.
// ---------------------------------------------------------------------------
package alr_pkg;

    localparam int LEVEL_BITS = 8;

    typedef logic [LEVEL_BITS-1:0] level_t;

endpackage

[design/alr_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alr_if
// Valid/ready channels: line command in, pixel pair out.
// ---------------------------------------------------------------------------
interface alr_line_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface alr_pair_if #(
    parameter int COORD_BITS = 6
);
    import alr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] near_x;
    logic [COORD_BITS-1:0] near_y;
    logic [COORD_BITS-1:0] far_x;
    logic [COORD_BITS-1:0] far_y;
    level_t                near_level;
    level_t                far_level;
    logic                  last;

    modport source (output valid, near_x, near_y, far_x, far_y, near_level, far_level, last,
                    input ready);
    modport sink   (input valid, near_x, near_y, far_x, far_y, near_level, far_level, last,
                    output ready);
endinterface

[design/alr_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module alr_div #(
    parameter int NUM_BITS = 23,
    parameter int DEN_BITS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] numer,
    input  logic [DEN_BITS-1:0] denom,
    output logic                done,
    output logic [NUM_BITS-1:0] quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [NUM_BITS-1:0] quot_reg, quot_next;

    logic [DEN_BITS:0]   rem_sh;
    logic [DEN_BITS:0]   diff;
    logic                fits;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NUM_BITS-1]};
        diff   = rem_sh - {1'b0, den_reg};
        fits   = (rem_sh >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quot_next = quot_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(NUM_BITS);
            rem_next  = '0;
            den_next  = denom;
            num_next  = numer;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
            quot_next = {quot_reg[NUM_BITS-2:0], fits};
            num_next  = {num_reg[NUM_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[design/antialiased_line_rasterizer.sv]
`timescale 1ns / 1ps
// Sequence: accept, a setup state (ST_PREP), the bit-serial gradient divider (ST_DIV), then
// the walk (ST_WALK): one pair per cycle while the output is not stalled, |dmajor|+1 pairs.
// A new line is accepted only back in ST_IDLE, once the gradient divider and the walk of the
// single error accumulator have finished with the last line.
// Reset: asynchronous, clears the sequencer and empties the output register.
// ---------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu-style antialiased line walker with coverage pairs per major step.
// ---------------------------------------------------------------------------
`include "antialiased_line_rasterizer_macros.svh"

module antialiased_line_rasterizer #(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    alr_line_if.sink   cmd,
    alr_pair_if.source pix
);
    import alr_pkg::*;

    localparam int NUM_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int PROD_BITS = FRAC_BITS + 1 + LEVEL_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_WALK = 2'd3;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
    localparam logic [FRAC_BITS:0]    FIX_ONE   = {1'b1, {FRAC_BITS{1'b0}}};

    logic [1:0]            state_reg, state_next;
    logic                  steep_reg, steep_next;
    logic                  dir_neg_reg, dir_neg_next;
    logic [COORD_BITS-1:0] maj_reg, maj_next;
    logic [COORD_BITS-1:0] maj1_reg, maj1_next;
    logic [COORD_BITS-1:0] minor_reg, minor_next;
    logic [COORD_BITS-1:0] dmin_reg, dmin_next;
    logic [COORD_BITS-1:0] dmaj_reg, dmaj_next;
    logic [FRAC_BITS:0]    grad_reg, grad_next;
    logic [FRAC_BITS-1:0]  err_reg, err_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] near_x_reg, near_x_next;
    logic [COORD_BITS-1:0] near_y_reg, near_y_next;
    logic [COORD_BITS-1:0] far_x_reg, far_x_next;
    logic [COORD_BITS-1:0] far_y_reg, far_y_next;
    level_t                near_lvl_reg, near_lvl_next;
    level_t                far_lvl_reg, far_lvl_next;
    logic                  last_reg, last_next;

    // command setup
    logic [COORD_BITS-1:0] adx, ady;
    logic                  steep;
    logic [COORD_BITS-1:0] a_maj0, a_maj1, a_min0, a_min1;
    logic                  swap;
    logic [COORD_BITS-1:0] s_maj0, s_maj1, s_min0, s_min1;

    // divider
    logic                  div_start;
    logic [NUM_BITS-1:0]   div_numer;
    logic                  div_done;
    logic [NUM_BITS-1:0]   div_quot;

    // walk datapath
    logic                  load;
    logic                  at_end;
    logic [COORD_BITS-1:0] far_minor;
    logic [FRAC_BITS:0]    inv_err;
    logic [PROD_BITS-1:0]  near_prod, far_prod;
    logic [FRAC_BITS:0]    err_sum;

    assign cmd.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        adx    = (cmd.end_x > cmd.start_x) ? cmd.end_x - cmd.start_x : cmd.start_x - cmd.end_x;
        ady    = (cmd.end_y > cmd.start_y) ? cmd.end_y - cmd.start_y : cmd.start_y - cmd.end_y;
        steep  = (ady > adx);
        a_maj0 = steep ? cmd.start_y : cmd.start_x;
        a_maj1 = steep ? cmd.end_y   : cmd.end_x;
        a_min0 = steep ? cmd.start_x : cmd.start_y;
        a_min1 = steep ? cmd.end_x   : cmd.end_y;
        swap   = (a_maj0 > a_maj1);
        s_maj0 = swap ? a_maj1 : a_maj0;
        s_maj1 = swap ? a_maj0 : a_maj1;
        s_min0 = swap ? a_min1 : a_min0;
        s_min1 = swap ? a_min0 : a_min1;
    end

    // ceil(dmin * ONE / dmaj); a zero-length line never uses the gradient
    assign div_start = (state_reg == ST_PREP);
    assign div_numer = (dmaj_reg == '0) ? '0 :
                       {1'b0, dmin_reg, {FRAC_BITS{1'b0}}}
                       + NUM_BITS'(dmaj_reg) - NUM_BITS'(1);

    alr_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (COORD_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (dmaj_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        load   = (state_reg == ST_WALK) && (!out_valid_reg || pix.ready);
        at_end = (maj_reg == maj1_reg);

        if (dir_neg_reg)
            far_minor = (minor_reg == '0) ? '0 : minor_reg - 1'b1;
        else
            far_minor = (minor_reg == COORD_MAX) ? COORD_MAX : minor_reg + 1'b1;

        // x * 255 as (x << 8) - x
        inv_err   = FIX_ONE - {1'b0, err_reg};
        near_prod = {inv_err, {LEVEL_BITS{1'b0}}} - PROD_BITS'(inv_err);
        far_prod  = {1'b0, err_reg, {LEVEL_BITS{1'b0}}} - PROD_BITS'(err_reg);
        err_sum   = {1'b0, err_reg} + grad_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        steep_next     = steep_reg;
        dir_neg_next   = dir_neg_reg;
        maj_next       = maj_reg;
        maj1_next      = maj1_reg;
        minor_next     = minor_reg;
        dmin_next      = dmin_reg;
        dmaj_next      = dmaj_reg;
        grad_next      = grad_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        near_x_next    = near_x_reg;
        near_y_next    = near_y_reg;
        far_x_next     = far_x_reg;
        far_y_next     = far_y_reg;
        near_lvl_next  = near_lvl_reg;
        far_lvl_next   = far_lvl_reg;
        last_next      = last_reg;

        if (out_valid_reg && pix.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    steep_next   = steep;
                    dir_neg_next = (s_min1 < s_min0);
                    maj_next     = s_maj0;
                    maj1_next    = s_maj1;
                    minor_next   = s_min0;
                    dmaj_next    = s_maj1 - s_maj0;
                    dmin_next    = (s_min1 > s_min0) ? s_min1 - s_min0 : s_min0 - s_min1;
                    err_next     = '0;
                    state_next   = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    grad_next  = div_quot[FRAC_BITS:0];
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    near_x_next    = steep_reg ? minor_reg : maj_reg;
                    near_y_next    = steep_reg ? maj_reg   : minor_reg;
                    far_x_next     = steep_reg ? far_minor : maj_reg;
                    far_y_next     = steep_reg ? maj_reg   : far_minor;
                    near_lvl_next  = near_prod[FRAC_BITS+LEVEL_BITS-1:FRAC_BITS];
                    far_lvl_next   = far_prod[FRAC_BITS+LEVEL_BITS-1:FRAC_BITS];
                    last_next      = at_end;

                    maj_next = maj_reg + 1'b1;
                    if (err_sum[FRAC_BITS])
                    begin
                        err_next   = err_sum[FRAC_BITS-1:0];
                        minor_next = far_minor;
                    end
                    else
                    begin
                        err_next = err_sum[FRAC_BITS-1:0];
                    end
                    if (at_end)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steep_reg    <= steep_next;
        dir_neg_reg  <= dir_neg_next;
        maj_reg      <= maj_next;
        maj1_reg     <= maj1_next;
        minor_reg    <= minor_next;
        dmin_reg     <= dmin_next;
        dmaj_reg     <= dmaj_next;
        grad_reg     <= grad_next;
        err_reg      <= err_next;
        near_x_reg   <= near_x_next;
        near_y_reg   <= near_y_next;
        far_x_reg    <= far_x_next;
        far_y_reg    <= far_y_next;
        near_lvl_reg <= near_lvl_next;
        far_lvl_reg  <= far_lvl_next;
        last_reg     <= last_next;
    end

    assign pix.valid      = out_valid_reg;
    assign pix.near_x     = near_x_reg;
    assign pix.near_y     = near_y_reg;
    assign pix.far_x      = far_x_reg;
    assign pix.far_y      = far_y_reg;
    assign pix.near_level = near_lvl_reg;
    assign pix.far_level  = far_lvl_reg;
    assign pix.last       = last_reg;

    // walk never runs past the end point
    `ALR_ASSERT_NOW(a_walk_in_range, clk, rst_n, state_reg == ST_WALK, maj_reg <= maj1_reg)
    // a pending non-final beat means the line is still being walked
    `ALR_ASSERT_NOW(a_mid_line_walking, clk, rst_n, out_valid_reg && !last_reg,
                    state_reg == ST_WALK)
    // the divider only finishes while the sequencer waits for it
    `ALR_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_done, state_reg == ST_DIV)
    // an accepted command always starts the gradient setup
    `ALR_ASSERT_NEXT(a_accept_to_prep, clk, rst_n, cmd.valid && cmd.ready,
                     state_reg == ST_PREP)

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the antialiased line rasterizer. Line commands go in
// over a valid/ready channel. Every pixel pair that a line should produce is
// predicted when its command beat is accepted, and each output beat is
// compared field by field with the oldest prediction. Both sides idle at
// random over several phases. One long output hold-off backs up the block.
// ---------------------------------------------------------------------------
module testbench;
    import alr_pkg::*;

    localparam int CB             = 6;
    localparam int FB             = 16;
    localparam int COORD_MAX      = (1 << CB) - 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 100;
    localparam int MAX_REPORTS    = 10;

    typedef logic [CB-1:0] coord_t;
    typedef longint unsigned fix_t;

    localparam fix_t FIX_ONE = fix_t'(1) << FB;

    typedef struct packed {
        coord_t near_x;
        coord_t near_y;
        coord_t far_x;
        coord_t far_y;
        level_t near_level;
        level_t far_level;
        logic   last;
    } pair_t;

    class pixel_scoreboard;
        pair_t pending_pairs[$];
        int    fails;
        int    reported;

        function string pair_str(pair_t p);
            return $sformatf("near=(%0d,%0d) far=(%0d,%0d) levels=%0d/%0d last=%0b",
                             p.near_x, p.near_y, p.far_x, p.far_y,
                             p.near_level, p.far_level, p.last);
        endfunction

        // Walks the line exactly as the block should and queues every pair.
        function void add_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            int    x0, y0, x1, y1;
            int    adx, ady, maj0, maj1, min0, min1, swap_v;
            int    dmaj, dmin, dir, minor, far_c;
            bit    steep;
            fix_t  grad, err;
            pair_t p;
            x0 = sx;
            y0 = sy;
            x1 = ex;
            y1 = ey;
            adx = (x1 > x0) ? x1 - x0 : x0 - x1;
            ady = (y1 > y0) ? y1 - y0 : y0 - y1;
            steep = ady > adx;
            if (steep)
            begin
                maj0 = y0; maj1 = y1; min0 = x0; min1 = x1;
            end
            else
            begin
                maj0 = x0; maj1 = x1; min0 = y0; min1 = y1;
            end
            if (maj0 > maj1)
            begin
                swap_v = maj0; maj0 = maj1; maj1 = swap_v;
                swap_v = min0; min0 = min1; min1 = swap_v;
            end
            dmaj = maj1 - maj0;
            dmin = (min1 > min0) ? min1 - min0 : min0 - min1;
            dir  = (min1 < min0) ? -1 : 1;
            // gradient rounded up so the walk lands on the end point
            grad = 0;
            if (dmaj > 0)
                grad = ((fix_t'(dmin) << FB) + fix_t'(dmaj - 1)) / fix_t'(dmaj);
            err   = 0;
            minor = min0;
            for (int i = 0; i <= dmaj; i++)
            begin
                far_c = minor + dir;
                if (far_c < 0)
                    far_c = 0;
                if (far_c > COORD_MAX)
                    far_c = COORD_MAX;
                if (steep)
                begin
                    p.near_x = coord_t'(minor);
                    p.near_y = coord_t'(maj0 + i);
                    p.far_x  = coord_t'(far_c);
                    p.far_y  = coord_t'(maj0 + i);
                end
                else
                begin
                    p.near_x = coord_t'(maj0 + i);
                    p.near_y = coord_t'(minor);
                    p.far_x  = coord_t'(maj0 + i);
                    p.far_y  = coord_t'(far_c);
                end
                p.near_level = level_t'(((FIX_ONE - err) * 255) >> FB);
                p.far_level  = level_t'((err * 255) >> FB);
                p.last       = (i == dmaj);
                pending_pairs.push_back(p);
                err += grad;
                if (err >= FIX_ONE)
                begin
                    err -= FIX_ONE;
                    minor += dir;
                end
            end
        endfunction

        function void check_pair(pair_t got);
            pair_t want;
            bit    bad;
            if (pending_pairs.size() == 0)
            begin
                fails++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("unexpected pixel pair: %s", pair_str(got));
                end
                return;
            end
            want = pending_pairs.pop_front();
            bad = (got.near_x !== want.near_x) || (got.near_y !== want.near_y) ||
                  (got.far_x !== want.far_x) || (got.far_y !== want.far_y) ||
                  (got.near_level !== want.near_level) ||
                  (got.far_level !== want.far_level) || (got.last !== want.last);
            if (bad)
            begin
                fails++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("pixel pair mismatch at %0t", $time);
                    $display("  expected %s", pair_str(want));
                    $display("  actual   %s", pair_str(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    alr_line_if #(.COORD_BITS(CB)) cmd_ch ();
    alr_pair_if #(.COORD_BITS(CB)) pix_ch ();

    antialiased_line_rasterizer #(
        .COORD_BITS(CB),
        .FRAC_BITS (FB)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .pix  (pix_ch)
    );

    pixel_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Accepted beats on both channels.
    always @(posedge clk)
    begin : beat_monitor
        pair_t got;
        if (rst_n === 1'b1 && cmd_ch.valid && cmd_ch.ready)
            sb.add_line(cmd_ch.start_x, cmd_ch.start_y, cmd_ch.end_x, cmd_ch.end_y);
        if (rst_n === 1'b1 && pix_ch.valid && pix_ch.ready)
        begin
            got.near_x     = pix_ch.near_x;
            got.near_y     = pix_ch.near_y;
            got.far_x      = pix_ch.far_x;
            got.far_y      = pix_ch.far_y;
            got.near_level = pix_ch.near_level;
            got.far_level  = pix_ch.far_level;
            got.last       = pix_ch.last;
            sb.check_pair(got);
        end
    end

    // Output side: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            pix_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            pix_ch.ready <= 1'b0;
        end
        else
            pix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int clip(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Called right after an edge; valid stays high until the next call decides.
    task automatic send_line(input int sx, input int sy, input int ex, input int ey);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.start_x <= coord_t'(sx);
        cmd_ch.start_y <= coord_t'(sy);
        cmd_ch.end_x   <= coord_t'(ex);
        cmd_ch.end_y   <= coord_t'(ey);
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_pairs.size() != 0);
    endtask

    task automatic send_random(input int count);
        int sx, sy, ex, ey, kind;
        repeat (count)
        begin
            sx   = $urandom_range(COORD_MAX);
            sy   = $urandom_range(COORD_MAX);
            ex   = $urandom_range(COORD_MAX);
            ey   = $urandom_range(COORD_MAX);
            kind = $urandom_range(9);
            case (kind)
                0: begin
                    ex = sx;
                    ey = sy;
                end
                1: ey = sy;
                2: ex = sx;
                3, 4, 5: begin
                    // short lines keep most commands cheap
                    ex = clip(sx + int'($urandom_range(14)) - 7);
                    ey = clip(sy + int'($urandom_range(14)) - 7);
                end
                default: ;
            endcase
            send_line(sx, sy, ex, ey);
        end
    endtask

    task automatic send_directed();
        send_line(5, 5, 5, 5);          // single point
        send_line(0, 0, 0, 0);
        send_line(63, 63, 63, 63);
        send_line(0, 0, 63, 0);         // flat, full width
        send_line(63, 63, 0, 63);       // reversed, far pixel clamped at edge
        send_line(0, 0, 0, 63);         // vertical
        send_line(63, 63, 63, 0);       // reversed vertical on the edge
        send_line(0, 0, 63, 63);        // diagonal, not steep
        send_line(63, 0, 0, 63);
        send_line(0, 63, 63, 0);
        send_line(0, 0, 63, 20);        // shallow, levels may sum to 254
        send_line(10, 40, 3, 0);        // steep, reversed
        send_line(0, 5, 10, 0);         // minor runs down to 0, far clamps
        send_line(5, 0, 0, 10);
        send_line(0, 0, 62, 63);        // barely steep
        send_line(0, 0, 63, 62);
        send_line(1, 2, 2, 1);
        send_line(0, 0, 1, 0);
        send_line(0, 0, 63, 1);
        send_line(0, 0, 1, 63);
        send_line(42, 21, 21, 42);
        send_line(21, 42, 42, 21);
        send_line(62, 63, 63, 0);
    endtask

    initial
    begin
        sb             = new;
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.start_x = '0;
        cmd_ch.start_y = '0;
        cmd_ch.end_x   = '0;
        cmd_ch.end_y   = '0;
        pix_ch.ready   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        wait_drained();

        send_random(70);
        // long output hold-off while commands keep coming
        hold_req <= hold_req + 1;
        send_random(20);
        wait_drained();

        send_idle_pct <= 60;
        send_random(90);

        send_idle_pct  <= 0;
        recv_stall_pct <= 60;
        send_random(90);

        send_idle_pct  <= 29;
        recv_stall_pct <= 29;
        send_random(90);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.pending_pairs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/alr_pkg.sv
design/alr_if.sv
design/alr_div.sv
design/antialiased_line_rasterizer.sv
tb/sv/testbench.sv
